@@ src/ssa_pkg.sv @@
package ssa_pkg;

    localparam int MAX_SLOTS   = 64;
    localparam int SLOT_AW     = 6;
    localparam int SLOT_CW     = 7;
    localparam int MAX_VISIBLE = 256;
    localparam int LIST_AW     = 8;
    localparam int LIST_CW     = 9;
    localparam int ROW_BITS    = 20;

    localparam logic [1:0] OP_ADD       = 2'd0;
    localparam logic [1:0] OP_COMMIT    = 2'd1;
    localparam logic [1:0] OP_ROW_LOOK  = 2'd2;
    localparam logic [1:0] OP_SLOT_LOOK = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ADD,
        ST_RS,
        ST_RS_GET,
        ST_SR,
        ST_SR_CMP,
        ST_C_RESIZE,
        ST_C_K_CHK,
        ST_C_K_GET,
        ST_C_K_DUP,
        ST_C_K_DCMP,
        ST_C_K_LRD,
        ST_C_K_LCMP,
        ST_C_P_START,
        ST_C_P_LRD,
        ST_C_P_GET,
        ST_C_P_TCHK,
        ST_C_P_TCMP,
        ST_C_P_FREE,
        ST_C_FIN,
        ST_DONE
    } st_t;

    typedef struct packed {
        logic                we;
        logic [SLOT_AW-1:0]  waddr;
        logic [ROW_BITS-1:0] wdata;
        logic [SLOT_AW-1:0]  raddr;
        logic                clr;
        logic [SLOT_AW-1:0]  clr_addr;
        logic                trunc;
        logic [SLOT_CW-1:0]  trunc_n;
    } tbl_ctrl_t;

endpackage

@@ src/ssa_table.sv @@
module ssa_table
    import ssa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tbl_ctrl_t             ctrl,
    output logic [ROW_BITS-1:0]   rdata,
    output logic [MAX_SLOTS-1:0]  valid
);

    logic [ROW_BITS-1:0]  mem [MAX_SLOTS];
    logic [ROW_BITS-1:0]  rdata_reg;
    logic [MAX_SLOTS-1:0] valid_reg;
    logic [MAX_SLOTS-1:0] valid_next;

    always_ff @(posedge clk)
    begin
        if (ctrl.we)
        begin
            mem[ctrl.waddr] <= ctrl.wdata;
        end
        rdata_reg <= mem[ctrl.raddr];
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (ctrl.trunc)
        begin
            for (int i = 0; i < MAX_SLOTS; i++)
            begin
                if (SLOT_CW'(i) >= ctrl.trunc_n)
                begin
                    valid_next[i] = 1'b0;
                end
            end
        end
        if (ctrl.clr)
        begin
            valid_next[ctrl.clr_addr] = 1'b0;
        end
        if (ctrl.we)
        begin
            valid_next[ctrl.waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign rdata = rdata_reg;
    assign valid = valid_reg;

endmodule

@@ src/sticky_slot_assigner.sv @@
// A row add appends a row to the visible row list; a row-for-slot lookup reads one slot of the table.
// A slot-for-row lookup scans the pool of slots in turn until it finds the row.
// A commit walks slots and list, paced by the single registered read port of the slot table
// and of the row list.
// One transaction is in flight at a time; the input stalls until its result is loaded.
// Reset is asynchronous: the pool is empty and the row count and revision are zero, with no clearing pass.
module sticky_slot_assigner
    import ssa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          op,
    input  logic signed [20:0]  row,
    input  logic [6:0]          slot_index,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                changed,
    output logic [31:0]         revision,
    output logic signed [20:0]  found_row,
    output logic signed [6:0]   found_slot,
    output logic                list_overflow,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [6:0]          cfg_data
);

    st_t state_reg, state_next;

    logic [1:0]          op_reg, op_next;
    logic                row_ok_reg, row_ok_next;
    logic [ROW_BITS-1:0] row_reg, row_next;
    logic [6:0]          slot_reg, slot_next;
    logic [ROW_BITS-1:0] cur_reg, cur_next;
    logic [SLOT_CW-1:0]  i_reg, i_next;
    logic [SLOT_CW-1:0]  j_reg, j_next;
    logic [LIST_CW-1:0]  k_reg, k_next;
    logic [SLOT_CW-1:0]  free_reg, free_next;
    logic [SLOT_CW-1:0]  n_reg, n_next;
    logic [SLOT_CW-1:0]  pool_reg, pool_next;
    logic [LIST_CW-1:0]  cnt_reg, cnt_next;
    logic                ovf_reg, ovf_next;
    logic [31:0]         rev_reg, rev_next;
    logic                chg_reg, chg_next;
    logic [20:0]         fr_reg, fr_next;
    logic [6:0]          fs_reg, fs_next;
    logic                rovf_reg, rovf_next;
    logic [6:0]          slots_in_use_reg;

    logic                out_valid_reg, out_valid_next;
    logic                o_chg_reg, o_chg_next;
    logic [31:0]         o_rev_reg, o_rev_next;
    logic [20:0]         o_fr_reg, o_fr_next;
    logic [6:0]          o_fs_reg, o_fs_next;
    logic                o_ovf_reg, o_ovf_next;

    logic [ROW_BITS-1:0] list_mem [MAX_VISIBLE];
    logic [ROW_BITS-1:0] list_rdata_reg;
    logic                list_we;
    logic [LIST_AW-1:0]  list_waddr;
    logic [LIST_AW-1:0]  list_raddr;

    tbl_ctrl_t            tctl;
    logic [ROW_BITS-1:0]  tbl_rdata;
    logic [MAX_SLOTS-1:0] tbl_valid;

    ssa_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (tctl),
        .rdata (tbl_rdata),
        .valid (tbl_valid)
    );

    always_ff @(posedge clk)
    begin
        if (list_we)
        begin
            list_mem[list_waddr] <= row_reg;
        end
        list_rdata_reg <= list_mem[list_raddr];
    end

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        row_ok_next    = row_ok_reg;
        row_next       = row_reg;
        slot_next      = slot_reg;
        cur_next       = cur_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        free_next      = free_reg;
        n_next         = n_reg;
        pool_next      = pool_reg;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        rev_next       = rev_reg;
        chg_next       = chg_reg;
        fr_next        = fr_reg;
        fs_next        = fs_reg;
        rovf_next      = rovf_reg;
        out_valid_next = out_valid_reg && out_stall;
        o_chg_next     = o_chg_reg;
        o_rev_next     = o_rev_reg;
        o_fr_next      = o_fr_reg;
        o_fs_next      = o_fs_reg;
        o_ovf_next     = o_ovf_reg;
        list_we        = 1'b0;
        list_waddr     = cnt_reg[LIST_AW-1:0];
        list_raddr     = k_reg[LIST_AW-1:0];
        tctl           = '0;
        tctl.waddr     = free_reg[SLOT_AW-1:0];
        tctl.wdata     = cur_reg;
        tctl.raddr     = j_reg[SLOT_AW-1:0];
        tctl.clr_addr  = i_reg[SLOT_AW-1:0];
        tctl.trunc_n   = n_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = op;
                    row_ok_next = !row[20];
                    row_next    = row[ROW_BITS-1:0];
                    slot_next   = slot_index;
                    chg_next    = 1'b0;
                    fr_next     = '1;
                    fs_next     = '1;
                    rovf_next   = ovf_reg;
                    j_next      = '0;
                    case (op)
                        OP_ADD:       state_next = ST_ADD;
                        OP_COMMIT:    state_next = ST_C_RESIZE;
                        OP_ROW_LOOK:  state_next = ST_RS;
                        OP_SLOT_LOOK: state_next = ST_SR;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD:
            begin
                if (row_ok_reg)
                begin
                    if (cnt_reg < LIST_CW'(MAX_VISIBLE))
                    begin
                        list_we  = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next  = 1'b1;
                        rovf_next = 1'b1;
                    end
                end
                state_next = ST_DONE;
            end
            ST_RS:
            begin
                tctl.raddr = slot_reg[SLOT_AW-1:0];
                if (slot_reg < pool_reg)
                begin
                    state_next = ST_RS_GET;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RS_GET:
            begin
                if (tbl_valid[slot_reg[SLOT_AW-1:0]])
                begin
                    fr_next = {1'b0, tbl_rdata};
                end
                state_next = ST_DONE;
            end
            ST_SR:
            begin
                if (!row_ok_reg || j_reg >= pool_reg)
                begin
                    state_next = ST_DONE;
                end
                else if (tbl_valid[j_reg[SLOT_AW-1:0]])
                begin
                    state_next = ST_SR_CMP;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_SR_CMP:
            begin
                if (tbl_rdata == row_reg)
                begin
                    fs_next    = j_reg;
                    state_next = ST_DONE;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_SR;
                end
            end
            ST_C_RESIZE:
            begin
                if (slots_in_use_reg > SLOT_CW'(MAX_SLOTS))
                begin
                    n_next = SLOT_CW'(MAX_SLOTS);
                end
                else
                begin
                    n_next = slots_in_use_reg;
                end
                if (n_next != pool_reg)
                begin
                    tctl.trunc   = 1'b1;
                    tctl.trunc_n = n_next;
                    pool_next    = n_next;
                    chg_next     = 1'b1;
                end
                i_next     = '0;
                state_next = ST_C_K_CHK;
            end
            ST_C_K_CHK:
            begin
                tctl.raddr = i_reg[SLOT_AW-1:0];
                if (i_reg >= n_reg)
                begin
                    state_next = ST_C_P_START;
                end
                else if (tbl_valid[i_reg[SLOT_AW-1:0]])
                begin
                    state_next = ST_C_K_GET;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            ST_C_K_GET:
            begin
                cur_next   = tbl_rdata;
                j_next     = '0;
                state_next = ST_C_K_DUP;
            end
            ST_C_K_DUP:
            begin
                if (j_reg >= i_reg)
                begin
                    k_next     = '0;
                    state_next = ST_C_K_LRD;
                end
                else if (tbl_valid[j_reg[SLOT_AW-1:0]])
                begin
                    state_next = ST_C_K_DCMP;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_C_K_DCMP:
            begin
                if (tbl_rdata == cur_reg)
                begin
                    tctl.clr   = 1'b1;
                    chg_next   = 1'b1;
                    i_next     = i_reg + 1'b1;
                    state_next = ST_C_K_CHK;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_C_K_DUP;
                end
            end
            ST_C_K_LRD:
            begin
                if (k_reg >= cnt_reg)
                begin
                    tctl.clr   = 1'b1;
                    chg_next   = 1'b1;
                    i_next     = i_reg + 1'b1;
                    state_next = ST_C_K_CHK;
                end
                else
                begin
                    state_next = ST_C_K_LCMP;
                end
            end
            ST_C_K_LCMP:
            begin
                if (list_rdata_reg == cur_reg)
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_C_K_CHK;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_C_K_LRD;
                end
            end
            ST_C_P_START:
            begin
                k_next     = '0;
                free_next  = '0;
                state_next = ST_C_P_LRD;
            end
            ST_C_P_LRD:
            begin
                if (k_reg >= cnt_reg)
                begin
                    state_next = ST_C_FIN;
                end
                else
                begin
                    state_next = ST_C_P_GET;
                end
            end
            ST_C_P_GET:
            begin
                cur_next   = list_rdata_reg;
                j_next     = '0;
                state_next = ST_C_P_TCHK;
            end
            ST_C_P_TCHK:
            begin
                if (j_reg >= n_reg)
                begin
                    state_next = ST_C_P_FREE;
                end
                else if (tbl_valid[j_reg[SLOT_AW-1:0]])
                begin
                    state_next = ST_C_P_TCMP;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_C_P_TCMP:
            begin
                if (tbl_rdata == cur_reg)
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_C_P_LRD;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_C_P_TCHK;
                end
            end
            ST_C_P_FREE:
            begin
                if (free_reg >= n_reg)
                begin
                    state_next = ST_C_FIN;
                end
                else if (tbl_valid[free_reg[SLOT_AW-1:0]])
                begin
                    free_next = free_reg + 1'b1;
                end
                else
                begin
                    tctl.we    = 1'b1;
                    chg_next   = 1'b1;
                    k_next     = k_reg + 1'b1;
                    state_next = ST_C_P_LRD;
                end
            end
            ST_C_FIN:
            begin
                if (chg_reg)
                begin
                    rev_next = rev_reg + 32'd1;
                end
                cnt_next   = '0;
                ovf_next   = 1'b0;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    o_chg_next     = chg_reg;
                    o_rev_next     = rev_reg;
                    o_fr_next      = fr_reg;
                    o_fs_next      = fs_reg;
                    o_ovf_next     = rovf_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            pool_reg         <= '0;
            cnt_reg          <= '0;
            ovf_reg          <= 1'b0;
            rev_reg          <= '0;
            out_valid_reg    <= 1'b0;
            slots_in_use_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pool_reg      <= pool_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            rev_reg       <= rev_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                slots_in_use_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        row_ok_reg <= row_ok_next;
        row_reg    <= row_next;
        slot_reg   <= slot_next;
        cur_reg    <= cur_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        free_reg   <= free_next;
        n_reg      <= n_next;
        chg_reg    <= chg_next;
        fr_reg     <= fr_next;
        fs_reg     <= fs_next;
        rovf_reg   <= rovf_next;
        o_chg_reg  <= o_chg_next;
        o_rev_reg  <= o_rev_next;
        o_fr_reg   <= o_fr_next;
        o_fs_reg   <= o_fs_next;
        o_ovf_reg  <= o_ovf_next;
    end

    assign out_valid     = out_valid_reg;
    assign changed       = o_chg_reg;
    assign revision      = o_rev_reg;
    assign found_row     = o_fr_reg;
    assign found_slot    = o_fs_reg;
    assign list_overflow = o_ovf_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= LIST_CW'(MAX_VISIBLE))
        else $error("Visible row count exceeds the list depth.");

    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pool_reg <= SLOT_CW'(MAX_SLOTS))
        else $error("Pool size exceeds the slot count.");

    a_commit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_C_FIN |=> cnt_reg == '0 && !ovf_reg)
        else $error("Commit did not empty the visible list.");

    a_rev_step: assert property (@(posedge clk) disable iff (!rst_n)
        rev_reg != $past(rev_reg) |-> rev_reg == $past(rev_reg) + 32'd1
            && $past(state_reg) == ST_C_FIN)
        else $error("Revision moved outside a commit or by more than one.");

    a_op_commit_path: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_C_RESIZE |-> op_reg == OP_COMMIT)
        else $error("Commit sequence entered for another operation.");
`endif

endmodule
